// ===== rtl/core/bech_pkg.sv =====
// Shared types, constants and helper functions for the Bech32 string codec.
// Depends on nothing; imported by the top level and by the checker.
package bech_pkg;

  localparam int unsigned CNT_W = 7;
  localparam int unsigned PREFIX_MAX_DEF = 83;
  localparam int unsigned DATA_MAX_DEF = 84;
  localparam int unsigned STRING_MAX_DEF = 90;
  localparam int unsigned STRING_MIN = 8;
  localparam int unsigned CHK_LEN = 6;

  localparam logic [CNT_W-1:0] DATA_ROOM_RST = 7'd84;
  localparam logic [CNT_W-1:0] CNT_SAT = 7'd127;

  // register indexes on the config port
  localparam logic REG_DIRECTION = 1'b0;
  localparam logic REG_DATA_ROOM = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [7:0] SEP_CHAR = 8'h31;
  localparam logic [7:0] PCHAR_LO = 8'd33;
  localparam logic [7:0] PCHAR_HI = 8'd126;
  localparam logic [7:0] UPPER_LO = 8'h41;
  localparam logic [7:0] UPPER_HI = 8'h5A;
  localparam logic [7:0] VALUE_LIM = 8'd32;

  localparam logic [29:0] GEN0 = 30'h3B6A57B2;
  localparam logic [29:0] GEN1 = 30'h26508E6D;
  localparam logic [29:0] GEN2 = 30'h1EA119FA;
  localparam logic [29:0] GEN3 = 30'h3D4233DD;
  localparam logic [29:0] GEN4 = 30'h2A1462B3;

  localparam logic [255:0] CHARSET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

  typedef struct packed {
    logic [7:0] in_value;
    logic       in_part;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_value;
    logic [1:0] out_kind;
    logic       out_status;
    logic       out_last;
  } out_item_t;

  // pending work steps of one transaction, in sequencing order
  typedef struct packed {
    logic echo_a;
    logic sep;
    logic sep1;
    logic echo_b;
    logic ck;
    logic status;
  } pend_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ECHO_A,
    ST_SEP0,
    ST_REP_RD,
    ST_REP_FD,
    ST_SEP1,
    ST_ECHO_B,
    ST_CK_FEED,
    ST_CK_EMIT,
    ST_STATUS,
    ST_DONE
  } st_t;

  // one polymod step
  function automatic logic [29:0] bech_feed(input logic [29:0] c, input logic [4:0] v);
    logic [4:0]  top;
    logic [29:0] r;
    top = c[29:25];
    r = {c[24:0], v};
    if (top[0]) r = r ^ GEN0;
    if (top[1]) r = r ^ GEN1;
    if (top[2]) r = r ^ GEN2;
    if (top[3]) r = r ^ GEN3;
    if (top[4]) r = r ^ GEN4;
    return r;
  endfunction

  function automatic logic [7:0] letter_of(input logic [4:0] v);
    return CHARSET[8*(31 - int'(v)) +: 8];
  endfunction

  // {hit, value}; uppercase folded to lowercase
  function automatic logic [5:0] letter_val(input logic [7:0] c);
    logic [7:0] lc;
    logic [5:0] r;
    lc = c;
    r = '0;
    if (c >= UPPER_LO && c <= UPPER_HI) lc = c + 8'd32;
    for (int i = 0; i < 32; i++) begin
      if (letter_of(5'(i)) == lc) r = {1'b1, 5'(i)};
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/bech_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bech_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/bech32_string_codec_top.sv =====
// Top level of the Bech32 string codec: sequencer, check register, counters.
// Depends on bech_pkg and bech_ram.
//
// Bech32 encoder/decoder. Configure direction (0 encode, 1 decode) and
// data_room while idle. Encode: send prefix characters (in_part 0), then
// 5-bit values (in_part 1); the block echoes the prefix, emits '1', the
// data letters and six checksum letters. Decode: send string characters;
// the block echoes the prefix, emits the data values and holds back the
// six checksum letters. Every request ends with one result carrying
// out_last and out_status. One transaction is in work at a time: no new
// item is taken until the last one is through, and each result waits for
// a free output register. At the separator the buffered low parts of the
// prefix are read back from the prefix RAM, each character read and then
// fed; an encoded checksum first feeds six zero values.
module bech32_string_codec_top #(
  parameter int unsigned PREFIX_MAX = bech_pkg::PREFIX_MAX_DEF,
  parameter int unsigned DATA_MAX   = bech_pkg::DATA_MAX_DEF,
  parameter int unsigned STRING_MAX = bech_pkg::STRING_MAX_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bech_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bech_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [6:0]          cfg_data
);

  import bech_pkg::*;

  localparam int unsigned AW = (PREFIX_MAX > 1) ? $clog2(PREFIX_MAX) : 1;

  // config
  logic             dir_r;
  logic [CNT_W-1:0] room_r;

  // request state
  logic [29:0]      chk_r, chk_nxt;
  logic [CNT_W-1:0] pc_r, pc_nxt;
  logic [CNT_W-1:0] partc_r, partc_nxt;
  logic [CNT_W-1:0] tot_r, tot_nxt;
  logic             phase_r, phase_nxt;
  logic             err_r, err_nxt;
  logic [4:0]       line_r [CHK_LEN];
  logic [4:0]       line_nxt [CHK_LEN];
  logic [2:0]       fill_r, fill_nxt;

  // sequencer
  st_t              st_r, st_nxt;
  pend_t            pend_r, pend_nxt, pend_acc;
  logic [7:0]       item_v_r, item_v_nxt;
  logic             item_last_r, item_last_nxt;
  logic [7:0]       echo_val_r, echo_val_nxt;
  logic [1:0]       echo_kind_r, echo_kind_nxt;
  logic             stat_val_r, stat_val_nxt;
  logic [CNT_W-1:0] rep_idx_r, rep_idx_nxt;
  logic [2:0]       ck_cnt_r, ck_cnt_nxt;

  // output register
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  // prefix RAM
  logic             mem_we, mem_re;
  logic [4:0]       mem_rdata;

  logic             in_fire, slot_free;
  logic [29:0]      mod_w;
  logic [4:0]       ck_sel;

  assign in_ready  = (st_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign mod_w  = chk_r ^ 30'd1;
  assign ck_sel = 5'(mod_w >> ((5 - int'(ck_cnt_r)) * 5));
  assign mem_re = (st_r == ST_REP_RD);

  bech_ram #(
    .WIDTH(5),
    .DEPTH(PREFIX_MAX)
  ) u_prefix_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(pc_r[AW-1:0]),
    .wdata(in_data.in_value[4:0]),
    .re   (mem_re),
    .raddr(rep_idx_r[AW-1:0]),
    .rdata(mem_rdata)
  );

  // first pending step
  function automatic st_t pick(input pend_t p);
    st_t s;
    s = ST_DONE;
    if (p.status) s = ST_STATUS;
    if (p.ck) s = ST_CK_FEED;
    if (p.echo_b) s = ST_ECHO_B;
    if (p.sep1) s = ST_SEP1;
    if (p.sep) s = ST_SEP0;
    if (p.echo_a) s = ST_ECHO_A;
    return s;
  endfunction

  // steps left once the current one is through
  function automatic pend_t rest_of(input pend_t p, input st_t s);
    pend_t r;
    r = p;
    r.echo_a = 1'b0;
    if (s != ST_ECHO_A) r.sep = 1'b0;
    if (s == ST_SEP1 || s == ST_ECHO_B || s == ST_CK_FEED || s == ST_CK_EMIT ||
        s == ST_STATUS) r.sep1 = 1'b0;
    if (s == ST_ECHO_B || s == ST_CK_FEED || s == ST_CK_EMIT || s == ST_STATUS)
      r.echo_b = 1'b0;
    if (s == ST_CK_FEED || s == ST_CK_EMIT || s == ST_STATUS) r.ck = 1'b0;
    if (s == ST_STATUS) r.status = 1'b0;
    return r;
  endfunction

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:    if (in_fire) st_nxt = pick(pend_acc);
      ST_ECHO_A, ST_SEP1, ST_ECHO_B, ST_STATUS: begin
        if (slot_free) st_nxt = pick(rest_of(pend_r, st_r));
      end
      ST_SEP0:    st_nxt = ST_REP_RD;
      ST_REP_RD:  st_nxt = ST_REP_FD;
      ST_REP_FD: begin
        if (rep_idx_r + 7'd1 == pc_r) st_nxt = pick(rest_of(pend_r, st_r));
        else st_nxt = ST_REP_RD;
      end
      ST_CK_FEED: if (ck_cnt_r == 3'(CHK_LEN - 1)) st_nxt = ST_CK_EMIT;
      ST_CK_EMIT: begin
        if (slot_free && ck_cnt_r == 3'(CHK_LEN - 1)) st_nxt = pick(rest_of(pend_r, st_r));
      end
      ST_DONE:    st_nxt = ST_IDLE;
      default:    st_nxt = ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    logic       pchar_ok, e, full;
    logic [5:0] lv;
    logic [7:0] partc_w;
    logic [2:0] fill_w;
    logic [29:0] chk_f;

    chk_nxt = chk_r;
    pc_nxt = pc_r;
    partc_nxt = partc_r;
    tot_nxt = tot_r;
    phase_nxt = phase_r;
    err_nxt = err_r;
    line_nxt = line_r;
    fill_nxt = fill_r;
    pend_nxt = pend_r;
    item_v_nxt = item_v_r;
    item_last_nxt = item_last_r;
    echo_val_nxt = echo_val_r;
    echo_kind_nxt = echo_kind_r;
    stat_val_nxt = stat_val_r;
    rep_idx_nxt = rep_idx_r;
    ck_cnt_nxt = ck_cnt_r;
    mem_we = 1'b0;
    pend_acc = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt = out_data_r;

    pchar_ok = in_data.in_value >= PCHAR_LO && in_data.in_value <= PCHAR_HI &&
               !(in_data.in_value >= UPPER_LO && in_data.in_value <= UPPER_HI);
    lv = letter_val(in_data.in_value);
    full = (fill_r == 3'(CHK_LEN));
    partc_w = {1'b0, partc_r} + 8'd1;
    fill_w = full ? fill_r : fill_r + 3'd1;
    chk_f = bech_feed(chk_r, lv[4:0]);
    e = 1'b0;

    unique case (st_r)
      ST_IDLE: begin
        if (in_fire) begin
          item_v_nxt = in_data.in_value;
          item_last_nxt = in_data.in_last;
          if (err_r) begin
            e = 1'b1;
          end else if (!dir_r) begin
            if (!in_data.in_part) begin
              e = phase_r || !pchar_ok || pc_r >= CNT_W'(PREFIX_MAX);
              if (!e) begin
                mem_we = 1'b1;
                pc_nxt = pc_r + 7'd1;
                chk_nxt = bech_feed(chk_r, {2'b00, in_data.in_value[7:5]});
                pend_acc.echo_a = 1'b1;
                echo_val_nxt = in_data.in_value;
                echo_kind_nxt = KIND_CHAR;
                if (in_data.in_last) begin
                  pend_acc.sep = 1'b1;
                  pend_acc.sep1 = 1'b1;
                  pend_acc.ck = 1'b1;
                end
              end
            end else begin
              e = (!phase_r && pc_r == '0) || in_data.in_value >= VALUE_LIM ||
                  partc_r >= CNT_W'(DATA_MAX);
              if (!e) begin
                if (!phase_r) begin
                  pend_acc.sep = 1'b1;
                  pend_acc.sep1 = 1'b1;
                  phase_nxt = 1'b1;
                end
                pend_acc.echo_b = 1'b1;
                pend_acc.ck = in_data.in_last;
              end
            end
          end else begin
            if (tot_r != CNT_SAT) tot_nxt = tot_r + 7'd1;
            if (!phase_r) begin
              if (in_data.in_value == SEP_CHAR) begin
                e = pc_r == '0 || in_data.in_last;
                if (!e) begin
                  pend_acc.sep = 1'b1;
                  phase_nxt = 1'b1;
                end
              end else begin
                e = !pchar_ok || pc_r >= CNT_W'(PREFIX_MAX) || in_data.in_last;
                if (!e) begin
                  mem_we = 1'b1;
                  pc_nxt = pc_r + 7'd1;
                  chk_nxt = bech_feed(chk_r, {2'b00, in_data.in_value[7:5]});
                  pend_acc.echo_a = 1'b1;
                  echo_val_nxt = in_data.in_value;
                  echo_kind_nxt = KIND_CHAR;
                end
              end
            end else begin
              e = !lv[5] ||
                  (full && (partc_w > {1'b0, room_r} || partc_w > 8'(DATA_MAX))) ||
                  (in_data.in_last && (tot_nxt < CNT_W'(STRING_MIN) ||
                   tot_nxt > CNT_W'(STRING_MAX) || fill_w != 3'(CHK_LEN) ||
                   chk_f != 30'd1));
              if (lv[5]) begin
                chk_nxt = chk_f;
                fill_nxt = fill_w;
                if (full) begin
                  for (int i = 0; i < CHK_LEN - 1; i++) line_nxt[i] = line_r[i+1];
                  line_nxt[CHK_LEN-1] = lv[4:0];
                  partc_nxt = partc_w[CNT_W-1:0];
                end else begin
                  line_nxt[fill_r] = lv[4:0];
                end
              end
              if (!e && full) begin
                pend_acc.echo_a = 1'b1;
                echo_val_nxt = {3'b000, line_r[0]};
                echo_kind_nxt = KIND_DATA;
              end
            end
          end
          if (e) begin
            err_nxt = 1'b1;
            pend_acc = '0;
          end
          if (in_data.in_last && (e || (!pend_acc.echo_a && !pend_acc.ck))) begin
            pend_acc.status = 1'b1;
          end
          stat_val_nxt = e;
          pend_nxt = pend_acc;
        end
      end
      ST_ECHO_A: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt = '{out_value: echo_val_r, out_kind: echo_kind_r, out_status: 1'b0,
                           out_last: item_last_r && !pend_r.ck};
        end
      end
      ST_SEP0: begin
        chk_nxt = bech_feed(chk_r, 5'd0);
        rep_idx_nxt = '0;
      end
      ST_REP_RD: ;
      ST_REP_FD: begin
        chk_nxt = bech_feed(chk_r, mem_rdata);
        rep_idx_nxt = rep_idx_r + 7'd1;
      end
      ST_SEP1: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt = '{out_value: SEP_CHAR, out_kind: KIND_CHAR, out_status: 1'b0,
                           out_last: 1'b0};
        end
      end
      ST_ECHO_B: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt = '{out_value: letter_of(item_v_r[4:0]), out_kind: KIND_CHAR,
                           out_status: 1'b0, out_last: 1'b0};
          chk_nxt = bech_feed(chk_r, item_v_r[4:0]);
          partc_nxt = partc_r + 7'd1;
          ck_cnt_nxt = '0;
        end
      end
      ST_CK_FEED: begin
        chk_nxt = bech_feed(chk_r, 5'd0);
        ck_cnt_nxt = (ck_cnt_r == 3'(CHK_LEN - 1)) ? 3'd0 : ck_cnt_r + 3'd1;
      end
      ST_CK_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt = '{out_value: letter_of(ck_sel), out_kind: KIND_CHAR,
                           out_status: 1'b0, out_last: ck_cnt_r == 3'(CHK_LEN - 1)};
          ck_cnt_nxt = ck_cnt_r + 3'd1;
        end
      end
      ST_STATUS: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt = '{out_value: 8'd0, out_kind: KIND_STATUS, out_status: stat_val_r,
                           out_last: 1'b1};
        end
      end
      ST_DONE: begin
        ck_cnt_nxt = '0;
        if (item_last_r) begin
          chk_nxt = 30'd1;
          pc_nxt = '0;
          partc_nxt = '0;
          tot_nxt = '0;
          phase_nxt = 1'b0;
          err_nxt = 1'b0;
          fill_nxt = '0;
          for (int i = 0; i < CHK_LEN; i++) line_nxt[i] = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= 1'b0;
      room_r <= DATA_ROOM_RST;
      chk_r <= 30'd1;
      pc_r <= '0;
      partc_r <= '0;
      tot_r <= '0;
      phase_r <= 1'b0;
      err_r <= 1'b0;
      fill_r <= '0;
      for (int i = 0; i < CHK_LEN; i++) line_r[i] <= '0;
      st_r <= ST_IDLE;
      pend_r <= '0;
      item_last_r <= 1'b0;
      rep_idx_r <= '0;
      ck_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_DIRECTION: dir_r <= cfg_data[0];
          REG_DATA_ROOM: room_r <= cfg_data;
          default: ;
        endcase
      end
      chk_r <= chk_nxt;
      pc_r <= pc_nxt;
      partc_r <= partc_nxt;
      tot_r <= tot_nxt;
      phase_r <= phase_nxt;
      err_r <= err_nxt;
      fill_r <= fill_nxt;
      line_r <= line_nxt;
      st_r <= st_nxt;
      pend_r <= pend_nxt;
      item_last_r <= item_last_nxt;
      rep_idx_r <= rep_idx_nxt;
      ck_cnt_r <= ck_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    item_v_r <= item_v_nxt;
    echo_val_r <= echo_val_nxt;
    echo_kind_r <= echo_kind_nxt;
    stat_val_r <= stat_val_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== rtl/core/bech_chk.sv =====
// Port-level checker for the Bech32 string codec, bound to the top level.
// Depends on bech_pkg.
module bech_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input bech_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input bech_pkg::out_item_t out_data,
  input logic                cfg_valid,
  input logic                cfg_ready,
  input logic                cfg_index,
  input logic [6:0]          cfg_data
);

  import bech_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_kind == KIND_STATUS |->
      out_data.out_last && out_data.out_value == 8'd0)
    else $error("status result not final or carries payload");

  a_status_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.out_last |-> !out_data.out_status)
    else $error("reject flag on a non-final result");

  a_data_width: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_kind == KIND_DATA |-> out_data.out_value[7:5] == 3'd0)
    else $error("decoded value wider than 5 bits");

  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_status |-> out_data.out_kind == KIND_STATUS)
    else $error("rejected request ended on a payload result");

endmodule

bind bech32_string_codec_top bech_chk u_bech_chk (.*);
